@@ hdl/bfa_pkg.sv @@
package bfa_pkg;

	localparam int NumHoles = 32;
	localparam int NumLive = 32;
	localparam int AddrW = 20;
	localparam int LenW = AddrW + 1;
	localparam int HIdxW = $clog2(NumHoles);
	localparam int LIdxW = $clog2(NumLive);
	localparam int NeedW = LenW + 1;

	localparam logic [LenW-1:0] PoolMax = LenW'(1) << AddrW;

	localparam logic [1:0] FN_ALLOC = 2'd0;
	localparam logic [1:0] FN_FREE = 2'd1;
	localparam logic [1:0] FN_RESET = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_IGNORED = 3'd1;
	localparam logic [2:0] ST_NO_MEM = 3'd2;
	localparam logic [2:0] ST_BAD_ADDR = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic [1:0] CFG_ALIGN = 2'd0;
	localparam logic [1:0] CFG_MIN_SPLIT = 2'd1;
	localparam logic [1:0] CFG_POOL = 2'd2;

	typedef struct packed {
		logic [1:0]       func;
		logic [20:0]      req_size;
		logic [AddrW-1:0] req_addr;
	} in_t;

	typedef struct packed {
		logic [AddrW-1:0] grant_addr;
		logic [LenW-1:0]  grant_size;
		logic [2:0]       status;
		logic [LenW-1:0]  usage_now;
		logic [LenW-1:0]  usage_peak;
		logic [31:0]      alloc_total;
		logic [31:0]      free_total;
		logic [39:0]      bytes_granted_sum;
		logic [39:0]      bytes_released_sum;
	} out_t;

	// token walking down the hole chain
	typedef struct packed {
		logic             go;
		logic             best_ok;
		logic [HIdxW-1:0] best_idx;
		logic [AddrW-1:0] best_base;
		logic [LenW-1:0]  best_len;
		logic             prev_ok;
		logic [HIdxW-1:0] prev_idx;
		logic [LenW-1:0]  prev_len;
		logic             next_ok;
		logic [HIdxW-1:0] next_idx;
		logic [LenW-1:0]  next_len;
		logic             free_ok;
		logic [HIdxW-1:0] free_idx;
	} hole_tok_t;

	// broadcast to every hole cell
	typedef struct packed {
		logic [NeedW-1:0] need;
		logic [AddrW-1:0] addr;
		logic [NeedW-1:0] blk_end;
		logic             wr_en;
		logic [HIdxW-1:0] wr_idx;
		logic [AddrW-1:0] wr_base;
		logic [LenW-1:0]  wr_len;
		logic             wr_valid;
		logic             kill_en;
		logic [HIdxW-1:0] kill_idx;
		logic             init;
		logic [LenW-1:0]  init_len;
	} hole_op_t;

	typedef struct packed {
		logic             go;
		logic             free_ok;
		logic [LIdxW-1:0] free_idx;
		logic             hit_ok;
		logic [LIdxW-1:0] hit_idx;
		logic [LenW-1:0]  hit_len;
	} live_tok_t;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic             wr_en;
		logic [LIdxW-1:0] wr_idx;
		logic [AddrW-1:0] wr_base;
		logic [LenW-1:0]  wr_len;
		logic             kill_en;
		logic [LIdxW-1:0] kill_idx;
		logic             clear;
	} live_op_t;

endpackage

@@ hdl/best_fit_block_allocator_unit.sv @@
// best-fit pool allocator with coalescing over [0, pool_bytes). each request word
// (allocate, free, pool reset) yields exactly one result word with grant, status and
// usage counters as they stand after the request. free blocks and live blocks sit in
// two rows of 32 cells; a search token walks one cell per clock down each row. an
// allocate or free is decoded, walks the live row, then the hole row, then is updated
// and output; a free of an unknown address skips the hole row, while a pool reset, a
// zero-size allocate or an unused func code skips both rows. one request is in flight
// at a time; the result sits in an output register so the next word can be taken while
// it waits. a pool_bytes write takes effect at the next pool reset.
module best_fit_block_allocator_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  bfa_pkg::in_t   in_word,
	output logic           out_valid,
	input  logic           out_stall,
	output bfa_pkg::out_t  out_word,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_idx,
	input  logic [20:0]    cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LIVE = 3'd1;
	localparam logic [2:0] S_HOLE = 3'd2;
	localparam logic [2:0] S_UPD = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	// config registers
	logic [3:0]  align_q;
	logic [16:0] min_split_q;
	logic [20:0] pool_q;

	// statistics
	logic [bfa_pkg::LenW-1:0] in_use_q;
	logic [bfa_pkg::LenW-1:0] peak_q;
	logic [31:0]              grants_q;
	logic [31:0]              releases_q;
	logic [39:0]              granted_q;
	logic [39:0]              released_q;

	logic [2:0]                 state_q;
	bfa_pkg::in_t               req_q;
	logic [bfa_pkg::NeedW-1:0]  need_q;
	logic [bfa_pkg::NeedW-1:0]  end_q;
	logic                       live_go_q;
	logic                       hole_go_q;
	bfa_pkg::live_tok_t         lres_q;
	bfa_pkg::hole_tok_t         hres_q;
	logic [bfa_pkg::AddrW-1:0]  res_addr_q;
	logic [bfa_pkg::LenW-1:0]   res_size_q;
	logic [2:0]                 res_status_q;
	logic                       out_valid_q;
	bfa_pkg::out_t              out_q;

	bfa_pkg::hole_tok_t hole_tok [bfa_pkg::NumHoles+1];
	bfa_pkg::live_tok_t live_tok [bfa_pkg::NumLive+1];
	bfa_pkg::hole_op_t  hop;
	bfa_pkg::live_op_t  lop;

	logic                      accept;
	logic [3:0]                align_eff;
	logic [bfa_pkg::NeedW-1:0] align_mask;
	logic [bfa_pkg::NeedW-1:0] need_d;
	logic [bfa_pkg::LenW-1:0]  pool_eff;
	logic                      pool_reset_now;
	logic                      out_free;

	// upd-stage decisions
	logic                      split;
	logic [bfa_pkg::LenW-1:0]  got;
	logic [bfa_pkg::LenW-1:0]  use_add;
	logic [bfa_pkg::LenW-1:0]  merged_len;
	logic                      alloc_ok;
	logic                      free_ok;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// alignment clamps at 4 KiB
	assign align_eff = (align_q > 4'd12) ? 4'd12 : align_q;
	assign align_mask = (bfa_pkg::NeedW'(1) << align_eff) - bfa_pkg::NeedW'(1);
	assign need_d = (bfa_pkg::NeedW'(in_word.req_size) + align_mask) & ~align_mask;

	// pool size clamps to [1, 2^20]
	always_comb begin
		if (pool_q == '0) begin
			pool_eff = bfa_pkg::LenW'(1);
		end else if (pool_q > bfa_pkg::PoolMax) begin
			pool_eff = bfa_pkg::PoolMax;
		end else begin
			pool_eff = pool_q;
		end
	end

	assign pool_reset_now = accept && in_word.func == bfa_pkg::FN_RESET;

	// split only when the leftover exceeds min_split
	assign split = (bfa_pkg::NeedW'(hres_q.best_len) >
		(need_q + bfa_pkg::NeedW'(min_split_q)));
	assign got = split ? need_q[bfa_pkg::LenW-1:0] : hres_q.best_len;
	assign alloc_ok = hres_q.best_ok && lres_q.free_ok;
	assign free_ok = hres_q.prev_ok || hres_q.next_ok || hres_q.free_ok;
	assign use_add = in_use_q + got;
	always_comb begin
		merged_len = hres_q.prev_len + lres_q.hit_len;
		if (hres_q.next_ok) begin
			merged_len = merged_len + hres_q.next_len;
		end
	end

	// broadcasts to the hole row
	always_comb begin
		hop = '0;
		hop.need = need_q;
		hop.addr = req_q.req_addr;
		hop.blk_end = end_q;
		hop.init = pool_reset_now;
		hop.init_len = pool_eff;
		if (state_q == S_UPD) begin
			if (req_q.func == bfa_pkg::FN_ALLOC) begin
				if (alloc_ok) begin
					hop.wr_en = 1'b1;
					hop.wr_idx = hres_q.best_idx;
					hop.wr_base = hres_q.best_base + need_q[bfa_pkg::AddrW-1:0];
					hop.wr_len = hres_q.best_len - need_q[bfa_pkg::LenW-1:0];
					hop.wr_valid = split;
				end
			end else if (hres_q.prev_ok) begin
				// merge into the block below, swallow the one above
				hop.wr_en = 1'b1;
				hop.wr_idx = hres_q.prev_idx;
				hop.wr_base = req_q.req_addr - hres_q.prev_len[bfa_pkg::AddrW-1:0];
				hop.wr_len = merged_len;
				hop.wr_valid = 1'b1;
				hop.kill_en = hres_q.next_ok;
				hop.kill_idx = hres_q.next_idx;
			end else if (hres_q.next_ok) begin
				hop.wr_en = 1'b1;
				hop.wr_idx = hres_q.next_idx;
				hop.wr_base = req_q.req_addr;
				hop.wr_len = hres_q.next_len + lres_q.hit_len;
				hop.wr_valid = 1'b1;
			end else if (hres_q.free_ok) begin
				hop.wr_en = 1'b1;
				hop.wr_idx = hres_q.free_idx;
				hop.wr_base = req_q.req_addr;
				hop.wr_len = lres_q.hit_len;
				hop.wr_valid = 1'b1;
			end
		end
	end

	// broadcasts to the live row
	always_comb begin
		lop = '0;
		lop.addr = req_q.req_addr;
		lop.clear = pool_reset_now;
		if (state_q == S_UPD) begin
			if (req_q.func == bfa_pkg::FN_ALLOC) begin
				lop.wr_en = alloc_ok;
				lop.wr_idx = lres_q.free_idx;
				lop.wr_base = hres_q.best_base;
				lop.wr_len = got;
			end else begin
				lop.kill_en = free_ok;
				lop.kill_idx = lres_q.hit_idx;
			end
		end
	end

	always_comb begin
		hole_tok[0] = '0;
		hole_tok[0].go = hole_go_q;
		live_tok[0] = '0;
		live_tok[0].go = live_go_q;
	end

	for (genvar g = 0; g < bfa_pkg::NumHoles; g++) begin : g_hole
		bfa_hole_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (bfa_pkg::HIdxW'(g)),
			.op     (hop),
			.tok_in (hole_tok[g]),
			.tok_out(hole_tok[g+1])
		);
	end

	for (genvar g = 0; g < bfa_pkg::NumLive; g++) begin : g_live
		bfa_live_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (bfa_pkg::LIdxW'(g)),
			.op     (lop),
			.tok_in (live_tok[g]),
			.tok_out(live_tok[g+1])
		);
	end

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= 4'd8;
			min_split_q <= 17'd256;
			pool_q <= 21'd1048576;
		end else if (cfg_we) begin
			case (cfg_idx)
				bfa_pkg::CFG_ALIGN:     align_q <= cfg_data[3:0];
				bfa_pkg::CFG_MIN_SPLIT: min_split_q <= cfg_data[16:0];
				bfa_pkg::CFG_POOL:      pool_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_go_q <= 1'b0;
			hole_go_q <= 1'b0;
			in_use_q <= '0;
			peak_q <= '0;
			grants_q <= '0;
			releases_q <= '0;
			granted_q <= '0;
			released_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			live_go_q <= 1'b0;
			hole_go_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_addr_q <= '0;
						res_size_q <= '0;
						if ((in_word.func == bfa_pkg::FN_ALLOC && in_word.req_size != '0) ||
							in_word.func == bfa_pkg::FN_FREE) begin
							live_go_q <= 1'b1;
							state_q <= S_LIVE;
						end else if (in_word.func == bfa_pkg::FN_RESET) begin
							in_use_q <= '0;
							res_status_q <= bfa_pkg::ST_OK;
							state_q <= S_DONE;
						end else begin
							res_status_q <= bfa_pkg::ST_IGNORED;
							state_q <= S_DONE;
						end
					end
				end
				S_LIVE: begin
					if (live_tok[bfa_pkg::NumLive].go) begin
						if (req_q.func == bfa_pkg::FN_FREE && !live_tok[bfa_pkg::NumLive].hit_ok) begin
							res_status_q <= bfa_pkg::ST_BAD_ADDR;
							state_q <= S_DONE;
						end else begin
							hole_go_q <= 1'b1;
							state_q <= S_HOLE;
						end
					end
				end
				S_HOLE: begin
					if (hole_tok[bfa_pkg::NumHoles].go) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_DONE;
					if (req_q.func == bfa_pkg::FN_ALLOC) begin
						if (!hres_q.best_ok) begin
							res_status_q <= bfa_pkg::ST_NO_MEM;
						end else if (!lres_q.free_ok) begin
							res_status_q <= bfa_pkg::ST_FULL;
						end else begin
							res_status_q <= bfa_pkg::ST_OK;
							res_addr_q <= hres_q.best_base;
							res_size_q <= got;
							in_use_q <= use_add;
							if (use_add > peak_q) begin
								peak_q <= use_add;
							end
							grants_q <= grants_q + 32'd1;
							granted_q <= granted_q + 40'(got);
						end
					end else if (!free_ok) begin
						res_status_q <= bfa_pkg::ST_FULL;
					end else begin
						res_status_q <= bfa_pkg::ST_OK;
						res_addr_q <= req_q.req_addr;
						res_size_q <= lres_q.hit_len;
						in_use_q <= in_use_q - lres_q.hit_len;
						releases_q <= releases_q + 32'd1;
						released_q <= released_q + 40'(lres_q.hit_len);
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_word;
			need_q <= need_d;
		end
		if (live_tok[bfa_pkg::NumLive].go) begin
			lres_q <= live_tok[bfa_pkg::NumLive];
			end_q <= bfa_pkg::NeedW'(req_q.req_addr) +
				bfa_pkg::NeedW'(live_tok[bfa_pkg::NumLive].hit_len);
		end
		if (hole_tok[bfa_pkg::NumHoles].go) begin
			hres_q <= hole_tok[bfa_pkg::NumHoles];
		end
		if (state_q == S_DONE && out_free) begin
			out_q.grant_addr <= res_addr_q;
			out_q.grant_size <= res_size_q;
			out_q.status <= res_status_q;
			out_q.usage_now <= in_use_q;
			out_q.usage_peak <= peak_q;
			out_q.alloc_total <= grants_q;
			out_q.free_total <= releases_q;
			out_q.bytes_granted_sum <= granted_q;
			out_q.bytes_released_sum <= released_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_q;

	// a word is only taken with no request in flight
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == S_IDLE)
		else $error("word accepted while busy");

	// search tokens leave the rows only in their own phase
	a_live_tail: assert property (@(posedge clk) disable iff (!arst_n)
		live_tok[bfa_pkg::NumLive].go |-> state_q == S_LIVE)
		else $error("stray live token");

	a_hole_tail: assert property (@(posedge clk) disable iff (!arst_n)
		hole_tok[bfa_pkg::NumHoles].go |-> state_q == S_HOLE)
		else $error("stray hole token");

	// a finished result only replaces a taken one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("result overwritten");

endmodule

@@ hdl/bfa_hole_cell.sv @@
module bfa_hole_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bfa_pkg::HIdxW-1:0]     idx,
	input  bfa_pkg::hole_op_t             op,
	input  bfa_pkg::hole_tok_t            tok_in,
	output bfa_pkg::hole_tok_t            tok_out
);

	logic [bfa_pkg::AddrW-1:0] base_q;
	logic [bfa_pkg::LenW-1:0]  len_q;
	logic                      valid_q;
	bfa_pkg::hole_tok_t        tok_q;
	bfa_pkg::hole_tok_t        tok_d;
	logic [bfa_pkg::NeedW-1:0] top_addr;
	logic                      fits;
	logic                      better;

	assign top_addr = bfa_pkg::NeedW'(base_q) + bfa_pkg::NeedW'(len_q);
	assign fits = valid_q && (bfa_pkg::NeedW'(len_q) >= op.need);
	assign better = !tok_in.best_ok || (len_q < tok_in.best_len) ||
		((len_q == tok_in.best_len) && (base_q < tok_in.best_base));

	always_comb begin
		tok_d = tok_in;
		if (tok_in.go) begin
			if (fits && better) begin
				tok_d.best_ok = 1'b1;
				tok_d.best_idx = idx;
				tok_d.best_base = base_q;
				tok_d.best_len = len_q;
			end
			if (!tok_in.prev_ok && valid_q && top_addr == bfa_pkg::NeedW'(op.addr)) begin
				tok_d.prev_ok = 1'b1;
				tok_d.prev_idx = idx;
				tok_d.prev_len = len_q;
			end
			if (!tok_in.next_ok && valid_q && bfa_pkg::NeedW'(base_q) == op.blk_end) begin
				tok_d.next_ok = 1'b1;
				tok_d.next_idx = idx;
				tok_d.next_len = len_q;
			end
			if (!tok_in.free_ok && !valid_q) begin
				tok_d.free_ok = 1'b1;
				tok_d.free_idx = idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			valid_q <= (idx == '0);
			base_q <= '0;
			len_q <= bfa_pkg::PoolMax;
		end else begin
			tok_q <= tok_d;
			if (op.init) begin
				valid_q <= (idx == '0);
				base_q <= '0;
				len_q <= (idx == '0) ? op.init_len : '0;
			end else begin
				if (op.wr_en && op.wr_idx == idx) begin
					base_q <= op.wr_base;
					len_q <= op.wr_len;
					valid_q <= op.wr_valid;
				end
				if (op.kill_en && op.kill_idx == idx) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	assign tok_out = tok_q;

endmodule

@@ hdl/bfa_live_cell.sv @@
module bfa_live_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bfa_pkg::LIdxW-1:0] idx,
	input  bfa_pkg::live_op_t         op,
	input  bfa_pkg::live_tok_t        tok_in,
	output bfa_pkg::live_tok_t        tok_out
);

	logic [bfa_pkg::AddrW-1:0] base_q;
	logic [bfa_pkg::LenW-1:0]  len_q;
	logic                      valid_q;
	bfa_pkg::live_tok_t        tok_q;
	bfa_pkg::live_tok_t        tok_d;

	always_comb begin
		tok_d = tok_in;
		if (tok_in.go) begin
			if (!tok_in.free_ok && !valid_q) begin
				tok_d.free_ok = 1'b1;
				tok_d.free_idx = idx;
			end
			if (!tok_in.hit_ok && valid_q && base_q == op.addr) begin
				tok_d.hit_ok = 1'b1;
				tok_d.hit_idx = idx;
				tok_d.hit_len = len_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			valid_q <= 1'b0;
		end else begin
			tok_q <= tok_d;
			if (op.clear) begin
				valid_q <= 1'b0;
			end else if (op.wr_en && op.wr_idx == idx) begin
				valid_q <= 1'b1;
			end else if (op.kill_en && op.kill_idx == idx) begin
				valid_q <= 1'b0;
			end
		end
	end

	// entry payload, meaningful only while valid
	always_ff @(posedge clk) begin
		if (op.wr_en && op.wr_idx == idx) begin
			base_q <= op.wr_base;
			len_q <= op.wr_len;
		end
	end

	assign tok_out = tok_q;

endmodule

@@ tb/sv/best_fit_block_allocator_unit_tb.sv @@
`timescale 1ns / 1ps

module best_fit_block_allocator_unit_tb;

	// func code with no operation behind it
	localparam logic [1:0] FN_UNUSED = 2'd3;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	bfa_pkg::in_t  in_word;
	logic          out_valid;
	logic          out_stall;
	bfa_pkg::out_t out_word;
	logic          cfg_we;
	logic [1:0]    cfg_idx;
	logic [20:0]   cfg_data;

	best_fit_block_allocator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor state: free block table, live block table, usage counters
	logic [19:0] fb_base [bfa_pkg::NumHoles];
	logic [20:0] fb_len [bfa_pkg::NumHoles];
	logic        fb_ok [bfa_pkg::NumHoles];
	logic [19:0] lb_base [bfa_pkg::NumLive];
	logic [20:0] lb_len [bfa_pkg::NumLive];
	logic        lb_ok [bfa_pkg::NumLive];
	logic [20:0] bytes_in_use, bytes_peak;
	logic [31:0] n_allocs, n_frees;
	logic [39:0] sum_granted, sum_released;
	logic [3:0]  cur_align;
	logic [16:0] cur_split;
	logic [20:0] cur_pool;

	bfa_pkg::in_t  pending_words [$];
	bfa_pkg::out_t expected_results [$];
	int   errors;
	int   sender_idle_pct, receiver_stall_pct;

	always #5 clk = ~clk;

	function automatic logic [20:0] pool_limit();
		if (cur_pool == 0) return 21'd1;
		if (cur_pool > bfa_pkg::PoolMax) return bfa_pkg::PoolMax;
		return cur_pool;
	endfunction

	function automatic void clear_pool();
		for (int i = 0; i < bfa_pkg::NumHoles; i++) begin
			fb_ok[i] = 1'b0;
			fb_base[i] = '0;
			fb_len[i] = '0;
		end
		for (int i = 0; i < bfa_pkg::NumLive; i++) lb_ok[i] = 1'b0;
		fb_len[0] = pool_limit();
		fb_ok[0] = 1'b1;
		bytes_in_use = '0;
	endfunction

	function automatic logic [2:0] try_alloc(input logic [20:0] size,
			output logic [19:0] ga, output logic [20:0] gs);
		int best, slot;
		logic [21:0] align, need;
		logic [20:0] got;
		logic [19:0] base;
		best = -1;
		slot = -1;
		ga = '0;
		gs = '0;
		if (size == 0) return bfa_pkg::ST_IGNORED;
		align = 22'd1 << ((cur_align > 4'd12) ? 4'd12 : cur_align);
		need = ({1'b0, size} + align - 22'd1) & ~(align - 22'd1);
		for (int i = 0; i < bfa_pkg::NumHoles; i++) begin
			if (!fb_ok[i] || {1'b0, fb_len[i]} < need) continue;
			if (best < 0 || fb_len[i] < fb_len[best] ||
					(fb_len[i] == fb_len[best] && fb_base[i] < fb_base[best]))
				best = i;
		end
		if (best < 0) return bfa_pkg::ST_NO_MEM;
		for (int i = 0; i < bfa_pkg::NumLive; i++)
			if (!lb_ok[i]) begin
				slot = i;
				break;
			end
		if (slot < 0) return bfa_pkg::ST_FULL;
		base = fb_base[best];
		// split only when the leftover is bigger than the split threshold
		if ({2'b0, fb_len[best]} > {1'b0, need} + {6'b0, cur_split}) begin
			fb_base[best] = base + need[19:0];
			fb_len[best] = fb_len[best] - need[20:0];
			got = need[20:0];
		end else begin
			got = fb_len[best];
			fb_ok[best] = 1'b0;
		end
		lb_base[slot] = base;
		lb_len[slot] = got;
		lb_ok[slot] = 1'b1;
		bytes_in_use = bytes_in_use + got;
		if (bytes_in_use > bytes_peak) bytes_peak = bytes_in_use;
		n_allocs++;
		sum_granted = sum_granted + 40'(got);
		ga = base;
		gs = got;
		return bfa_pkg::ST_OK;
	endfunction

	function automatic logic [2:0] try_free(input logic [19:0] addr,
			output logic [19:0] ga, output logic [20:0] gs);
		int k, p, n, slot;
		logic [20:0] len;
		logic [21:0] blk_end;
		k = -1;
		p = -1;
		n = -1;
		slot = -1;
		ga = '0;
		gs = '0;
		for (int i = 0; i < bfa_pkg::NumLive; i++)
			if (lb_ok[i] && lb_base[i] == addr) begin
				k = i;
				break;
			end
		if (k < 0) return bfa_pkg::ST_BAD_ADDR;
		len = lb_len[k];
		blk_end = {2'b0, addr} + {1'b0, len};
		for (int i = 0; i < bfa_pkg::NumHoles; i++) begin
			if (!fb_ok[i]) continue;
			if (p < 0 && {2'b0, fb_base[i]} + {1'b0, fb_len[i]} == {2'b0, addr}) p = i;
			if (n < 0 && {2'b0, fb_base[i]} == blk_end) n = i;
		end
		if (p < 0 && n < 0) begin
			for (int i = 0; i < bfa_pkg::NumHoles; i++)
				if (!fb_ok[i]) begin
					slot = i;
					break;
				end
			if (slot < 0) return bfa_pkg::ST_FULL;
			fb_base[slot] = addr;
			fb_len[slot] = len;
			fb_ok[slot] = 1'b1;
		end else if (p >= 0) begin
			fb_len[p] = fb_len[p] + len;
			if (n >= 0) begin
				fb_len[p] = fb_len[p] + fb_len[n];
				fb_ok[n] = 1'b0;
			end
		end else begin
			fb_base[n] = addr;
			fb_len[n] = fb_len[n] + len;
		end
		lb_ok[k] = 1'b0;
		bytes_in_use = bytes_in_use - len;
		n_frees++;
		sum_released = sum_released + 40'(len);
		ga = addr;
		gs = len;
		return bfa_pkg::ST_OK;
	endfunction

	function automatic bfa_pkg::out_t predict_request(input bfa_pkg::in_t w);
		bfa_pkg::out_t r;
		logic [19:0] ga;
		logic [20:0] gs;
		logic [2:0] st;
		ga = '0;
		gs = '0;
		case (w.func)
			bfa_pkg::FN_ALLOC: st = try_alloc(w.req_size, ga, gs);
			bfa_pkg::FN_FREE: st = try_free(w.req_addr, ga, gs);
			bfa_pkg::FN_RESET: begin
				clear_pool();
				st = bfa_pkg::ST_OK;
			end
			default: st = bfa_pkg::ST_IGNORED;
		endcase
		r.grant_addr = ga;
		r.grant_size = gs;
		r.status = st;
		r.usage_now = bytes_in_use;
		r.usage_peak = bytes_peak;
		r.alloc_total = n_allocs;
		r.free_total = n_frees;
		r.bytes_granted_sum = sum_granted;
		r.bytes_released_sum = sum_released;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic void queue_word(input bfa_pkg::in_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	// driver: present the next word, hold it while stalled, idle at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.insert(expected_results.size(), predict_request(in_word));
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 &&
						$urandom_range(99) >= sender_idle_pct) begin
					in_word <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result word", 40'(out_word.status), '0);
				end else begin
					bfa_pkg::out_t e;
					e = expected_results.pop_front();
					if (out_word.grant_addr !== e.grant_addr)
						report_mismatch("grant_addr", 40'(out_word.grant_addr),
							40'(e.grant_addr));
					if (out_word.grant_size !== e.grant_size)
						report_mismatch("grant_size", 40'(out_word.grant_size),
							40'(e.grant_size));
					if (out_word.status !== e.status)
						report_mismatch("status", 40'(out_word.status), 40'(e.status));
					if (out_word.usage_now !== e.usage_now)
						report_mismatch("usage_now", 40'(out_word.usage_now),
							40'(e.usage_now));
					if (out_word.usage_peak !== e.usage_peak)
						report_mismatch("usage_peak", 40'(out_word.usage_peak),
							40'(e.usage_peak));
					if (out_word.alloc_total !== e.alloc_total)
						report_mismatch("alloc_total", 40'(out_word.alloc_total),
							40'(e.alloc_total));
					if (out_word.free_total !== e.free_total)
						report_mismatch("free_total", 40'(out_word.free_total),
							40'(e.free_total));
					if (out_word.bytes_granted_sum !== e.bytes_granted_sum)
						report_mismatch("bytes_granted_sum", out_word.bytes_granted_sum,
							e.bytes_granted_sum);
					if (out_word.bytes_released_sum !== e.bytes_released_sum)
						report_mismatch("bytes_released_sum", out_word.bytes_released_sum,
							e.bytes_released_sum);
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// live addresses the stimulus side believes are allocated, for realistic frees
	logic [19:0] held_addrs [$];

	function automatic bfa_pkg::in_t make_word(input logic [1:0] f, input logic [20:0] sz,
			input logic [19:0] ad);
		bfa_pkg::in_t w;
		w.func = f;
		w.req_size = sz;
		w.req_addr = ad;
		return w;
	endfunction

	// mostly small sizes, a few huge; frees mostly hit recent grants
	function automatic bfa_pkg::in_t random_word();
		int r;
		logic [20:0] sz;
		r = $urandom_range(99);
		if (r < 50) begin
			case ($urandom_range(9))
				0: sz = 21'($urandom_range(21'h1fffff));
				1: sz = 21'($urandom_range(1048576, 262144));
				2: sz = '0;
				default: sz = 21'($urandom_range(8192, 1));
			endcase
			return make_word(bfa_pkg::FN_ALLOC, sz, 20'($urandom));
		end
		if (r < 92) begin
			if (held_addrs.size() > 0 && $urandom_range(9) > 0)
				return make_word(bfa_pkg::FN_FREE, 21'($urandom),
					held_addrs[$urandom_range(held_addrs.size() - 1)]);
			return make_word(bfa_pkg::FN_FREE, 21'($urandom), 20'($urandom));
		end
		if (r < 97) return make_word(bfa_pkg::FN_RESET, 21'($urandom), 20'($urandom));
		return make_word(FN_UNUSED, 21'($urandom), 20'($urandom));
	endfunction

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		// zero-result case cannot occur, but let the output register settle
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
		cfg_idx <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bfa_pkg::CFG_ALIGN: cur_align = val[3:0];
			bfa_pkg::CFG_MIN_SPLIT: cur_split = val[16:0];
			default: cur_pool = val;
		endcase
	endtask

	// stimulus: directed corners, then random phases across settings and idling
	initial begin
		int phase;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		errors = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		cur_align = 4'd8;
		cur_split = 17'd256;
		cur_pool = 21'd1048576;
		bytes_peak = '0;
		n_allocs = '0;
		n_frees = '0;
		sum_granted = '0;
		sum_released = '0;
		clear_pool();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		queue_word(make_word(bfa_pkg::FN_ALLOC, 21'd0, 20'd0));
		queue_word(make_word(bfa_pkg::FN_ALLOC, 21'd1, 20'hfffff));
		queue_word(make_word(bfa_pkg::FN_ALLOC, 21'd300, 20'd0));
		queue_word(make_word(bfa_pkg::FN_ALLOC, 21'h1fffff, 20'd0));
		queue_word(make_word(bfa_pkg::FN_FREE, 21'd0, 20'd0));
		queue_word(make_word(bfa_pkg::FN_FREE, 21'd0, 20'd0));
		queue_word(make_word(bfa_pkg::FN_FREE, 21'd0, 20'd256));
		queue_word(make_word(bfa_pkg::FN_FREE, 21'h1fffff, 20'hfffff));
		queue_word(make_word(FN_UNUSED, 21'h1fffff, 20'hfffff));
		for (int i = 0; i < 33; i++)
			queue_word(make_word(bfa_pkg::FN_ALLOC, 21'd1, 20'd0));
		queue_word(make_word(bfa_pkg::FN_ALLOC, 21'd1048576, 20'd0));
		queue_word(make_word(bfa_pkg::FN_RESET, 21'd0, 20'd0));
		queue_word(make_word(bfa_pkg::FN_ALLOC, 21'd1048576, 20'd0));
		queue_word(make_word(bfa_pkg::FN_FREE, 21'd0, 20'd0));
		wait_drained();

		// scattered holes: alternate grants then free every other one
		write_reg(bfa_pkg::CFG_ALIGN, 21'd4);
		write_reg(bfa_pkg::CFG_MIN_SPLIT, 21'd0);
		queue_word(make_word(bfa_pkg::FN_RESET, 21'd0, 20'd0));
		for (int i = 0; i < 32; i++)
			queue_word(make_word(bfa_pkg::FN_ALLOC, 21'd16, 20'd0));
		for (int i = 0; i < 32; i += 2)
			queue_word(make_word(bfa_pkg::FN_FREE, 21'd0, 20'(i * 16)));
		wait_drained();

		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 65;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 65;
				end
				default: begin
					sender_idle_pct = 36;
					receiver_stall_pct = 36;
				end
			endcase
			case (phase)
				0: begin
					write_reg(bfa_pkg::CFG_ALIGN, 21'd0);
					write_reg(bfa_pkg::CFG_MIN_SPLIT, 21'd0);
					write_reg(bfa_pkg::CFG_POOL, 21'd1);
				end
				1: begin
					write_reg(bfa_pkg::CFG_ALIGN, 21'd12);
					write_reg(bfa_pkg::CFG_MIN_SPLIT, 21'd65536);
					write_reg(bfa_pkg::CFG_POOL, 21'd1048576);
				end
				2: begin
					write_reg(bfa_pkg::CFG_ALIGN, 21'd15);
					write_reg(bfa_pkg::CFG_MIN_SPLIT, 21'h1ffff);
					write_reg(bfa_pkg::CFG_POOL, 21'h1fffff);
				end
				3: begin
					write_reg(bfa_pkg::CFG_ALIGN, 21'd3);
					write_reg(bfa_pkg::CFG_MIN_SPLIT, 21'd64);
					write_reg(bfa_pkg::CFG_POOL, 21'd0);
				end
				default: begin
					write_reg(bfa_pkg::CFG_ALIGN, 21'($urandom_range(12)));
					write_reg(bfa_pkg::CFG_MIN_SPLIT, 21'($urandom_range(4096)));
					write_reg(bfa_pkg::CFG_POOL, 21'($urandom_range(1048576, 4096)));
				end
			endcase
			held_addrs.delete();
			queue_word(make_word(bfa_pkg::FN_RESET, 21'd0, 20'd0));
			for (int i = 0; i < 160; i++) begin
				bfa_pkg::in_t w;
				w = random_word();
				// stimulus side tracks plausible grants by peeking at predictions
				queue_word(w);
				if (pending_words.size() > 8)
					while (pending_words.size() > 8) @(posedge clk);
				if (expected_results.size() > 0 &&
						expected_results[$].status == bfa_pkg::ST_OK &&
						expected_results[$].grant_size != 0)
					held_addrs.insert(held_addrs.size(), expected_results[$].grant_addr);
				if (held_addrs.size() > 40) void'(held_addrs.pop_front());
			end
			wait_drained();
		end

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog: ~1400 words with heavy stalling, several times over
	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/bfa_pkg.sv
hdl/bfa_hole_cell.sv
hdl/bfa_live_cell.sv
hdl/best_fit_block_allocator_unit.sv
tb/sv/best_fit_block_allocator_unit_tb.sv
